FILE: src/rlc_pkg.sv
// Package for the ray/line closest-point block.
// Request and response types, datapath widths and register codes.
// No dependencies.
`default_nettype none
package rlc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int OPW = 68;   // dot product width, signed
  localparam int HW  = 34;   // half of OPW for partial products
  localparam int PW  = 136;  // product width, signed
  localparam int QB  = 33;   // quotient bits before rounding

  localparam int DW  = 32;   // APB data width
  localparam int AW  = 3;    // APB address width
  localparam logic REG_THR = 1'b0;  // register index, taken from paddr[2]
  localparam logic [31:0] THR_RESET = 32'd1;

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic signed [31:0] axis_origin_x;
    logic signed [31:0] axis_origin_y;
    logic signed [31:0] axis_origin_z;
    logic signed [31:0] axis_dir_x;
    logic signed [31:0] axis_dir_y;
    logic signed [31:0] axis_dir_z;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] line_param;
    logic               used_projection;
  } rsp_t;

  typedef struct packed {
    logic zero;
    logic proj;
    logic neg;
  } dtag_t;

endpackage
`default_nettype wire

FILE: src/rlc_mul.sv
// Three-stage signed 68x68 multiplier built from 34x34 partial products.
// Depends on rlc_pkg.
`default_nettype none
module rlc_mul (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [rlc_pkg::OPW-1:0] a,
  input  wire logic signed [rlc_pkg::OPW-1:0] b,
  output logic signed [rlc_pkg::PW-1:0]       p
);

  localparam int HW = rlc_pkg::HW;
  localparam int PW = rlc_pkg::PW;

  logic signed [2*HW-1:0] hh;
  logic signed [2*HW:0]   hl;
  logic signed [2*HW:0]   lh;
  logic        [2*HW-1:0] ll;
  logic signed [2*HW+1:0] mid;
  logic signed [PW-1:0]   hhll;

  always_ff @(posedge clk) begin
    if (en) begin
      hh   <= $signed(a[2*HW-1:HW]) * $signed(b[2*HW-1:HW]);
      hl   <= $signed(a[2*HW-1:HW]) * $signed({1'b0, b[HW-1:0]});
      lh   <= $signed({1'b0, a[HW-1:0]}) * $signed(b[2*HW-1:HW]);
      ll   <= a[HW-1:0] * b[HW-1:0];
      mid  <= (2*HW+2)'(hl) + (2*HW+2)'(lh);
      hhll <= {hh, ll};
      p    <= hhll + (PW'(mid) <<< HW);
    end
  end

endmodule
`default_nettype wire

FILE: src/rlc_div.sv
// Pipelined restoring divider: floor(mag * 2^(FRAC_BITS+1) / den), one bit a stage.
// Flags quotients wider than QB bits. Depends on rlc_pkg.
`default_nettype none
module rlc_div #(
  parameter int FRAC_BITS = rlc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [rlc_pkg::PW-1:0]   mag,
  input  wire logic [rlc_pkg::PW-1:0]   den,
  input  wire rlc_pkg::dtag_t           tag,
  output logic [rlc_pkg::QB-1:0]        quo,
  output logic                          ovf,
  output rlc_pkg::dtag_t                tag_out
);

  localparam int PW  = rlc_pkg::PW;
  localparam int QB  = rlc_pkg::QB;
  localparam int XSW = PW + QB;

  logic [PW-1:0]  rem_q [QB+1];
  logic [QB-1:0]  low_q [QB+1];
  logic [QB-1:0]  quo_q [QB+1];
  logic [PW-1:0]  den_q [QB+1];
  logic           ovf_q [QB+1];
  rlc_pkg::dtag_t tag_q [QB+1];

  logic [XSW-1:0] xs;

  assign xs = {{QB{1'b0}}, mag} << (FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= xs[XSW-1:QB];
      low_q[0] <= xs[QB-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den;
      ovf_q[0] <= xs[XSW-1:QB] >= den;
      tag_q[0] <= tag;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [PW:0] trial;
    logic        ge;
    assign trial = {rem_q[k-1], low_q[k-1][QB-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? PW'(trial - {1'b0, den_q[k-1]}) : PW'(trial);
        low_q[k] <= {low_q[k-1][QB-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QB-2:0], ge};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign quo     = quo_q[QB];
  assign ovf     = ovf_q[QB];
  assign tag_out = tag_q[QB];

endmodule
`default_nettype wire

FILE: src/ray_line_closest_param.sv
// Top level: closest point parameter along a line to a ray, fixed point.
// Depends on rlc_pkg, rlc_mul, rlc_div.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    rlc_pkg::req_t
//   rsp      out  rsp_valid/rsp_ready    rlc_pkg::rsp_t
//   apb      in   psel/penable/pready    paddr, pwdata, prdata
//
// One request per cycle while the spare output register is empty.
// rst is synchronous; it clears the valid bits and sets the threshold to 1.
// A stalled response sits in the output register; one more waits in a spare
// register, and the pipeline freezes only once that spare is full.
`default_nettype none
module ray_line_closest_param #(
  parameter int FRAC_BITS = rlc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_ready,
  input  wire rlc_pkg::req_t           req,
  output logic                         rsp_valid,
  input  wire logic                    rsp_ready,
  output rlc_pkg::rsp_t                rsp,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [rlc_pkg::AW-1:0]  paddr,
  input  wire logic [rlc_pkg::DW-1:0]  pwdata,
  output logic [rlc_pkg::DW-1:0]       prdata,
  output logic                         pready
);

  localparam int OPW = rlc_pkg::OPW;
  localparam int PW  = rlc_pkg::PW;
  localparam int QB  = rlc_pkg::QB;
  localparam int NS  = QB + 11;

  typedef struct packed {
    logic                  zero;
    logic signed [OPW-1:0] vv;
    logic signed [OPW-1:0] vw;
  } side_t;

  logic [31:0] thr;
  logic [NS-1:0] vld;
  logic en;

  // config
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rlc_pkg::REG_THR) ? thr : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rlc_pkg::THR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == rlc_pkg::REG_THR) begin
      thr <= pwdata;
    end
  end

  // stage 0: inputs, w = line origin - ray origin
  logic signed [31:0] u0 [3];
  logic signed [31:0] v0 [3];
  logic signed [32:0] w0 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      u0[0] <= req.ray_dir_x;
      u0[1] <= req.ray_dir_y;
      u0[2] <= req.ray_dir_z;
      v0[0] <= req.axis_dir_x;
      v0[1] <= req.axis_dir_y;
      v0[2] <= req.axis_dir_z;
      w0[0] <= 33'(req.axis_origin_x) - 33'(req.ray_origin_x);
      w0[1] <= 33'(req.axis_origin_y) - 33'(req.ray_origin_y);
      w0[2] <= 33'(req.axis_origin_z) - 33'(req.ray_origin_z);
    end
  end

  // stage 1: element products
  logic signed [63:0] puu [3];
  logic signed [63:0] pvv [3];
  logic signed [63:0] puv [3];
  logic signed [64:0] puw [3];
  logic signed [64:0] pvw [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        puu[i] <= u0[i] * u0[i];
        pvv[i] <= v0[i] * v0[i];
        puv[i] <= u0[i] * v0[i];
        puw[i] <= 65'(u0[i]) * 65'(w0[i]);
        pvw[i] <= 65'(v0[i]) * 65'(w0[i]);
      end
    end
  end

  // stage 2: dot products
  logic signed [OPW-1:0] uu, vv, uv, uw, vw;

  always_ff @(posedge clk) begin
    if (en) begin
      uu <= OPW'(puu[0]) + OPW'(puu[1]) + OPW'(puu[2]);
      vv <= OPW'(pvv[0]) + OPW'(pvv[1]) + OPW'(pvv[2]);
      uv <= OPW'(puv[0]) + OPW'(puv[1]) + OPW'(puv[2]);
      uw <= OPW'(puw[0]) + OPW'(puw[1]) + OPW'(puw[2]);
      vw <= OPW'(pvw[0]) + OPW'(pvw[1]) + OPW'(pvw[2]);
    end
  end

  // stages 3..5: wide products
  logic signed [PW-1:0] p_uuvv, p_uvuv, p_uwvv, p_vwuv, p_uwuv, p_vwuu;

  rlc_mul u_m0 (.clk, .en, .a(uu), .b(vv), .p(p_uuvv));
  rlc_mul u_m1 (.clk, .en, .a(uv), .b(uv), .p(p_uvuv));
  rlc_mul u_m2 (.clk, .en, .a(uw), .b(vv), .p(p_uwvv));
  rlc_mul u_m3 (.clk, .en, .a(vw), .b(uv), .p(p_vwuv));
  rlc_mul u_m4 (.clk, .en, .a(uw), .b(uv), .p(p_uwuv));
  rlc_mul u_m5 (.clk, .en, .a(vw), .b(uu), .p(p_vwuu));

  side_t s3, s4, s5, s6;

  always_ff @(posedge clk) begin
    if (en) begin
      s3.zero <= (uu == '0) || (vv == '0);
      s3.vv   <= vv;
      s3.vw   <= vw;
      s4 <= s3;
      s5 <= s4;
      s6 <= s5;
    end
  end

  // stage 6: determinant and numerators
  logic signed [PW-1:0] det6, ns6, nt6;

  always_ff @(posedge clk) begin
    if (en) begin
      det6 <= p_uuvv - p_uvuv;
      ns6  <= p_uwvv - p_vwuv;
      nt6  <= p_uwuv - p_vwuu;
    end
  end

  // stage 7: choose solve or projection
  logic                 proj;
  logic signed [PW-1:0] num7;
  logic [PW-1:0]        den7;
  logic                 proj7, zero7;

  assign proj = !($unsigned(det6) > PW'(thr)) || ns6[PW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      proj7 <= proj;
      zero7 <= s6.zero;
      num7  <= proj ? -PW'(s6.vw) : nt6;
      den7  <= proj ? $unsigned(PW'(s6.vv)) : $unsigned(det6);
    end
  end

  // stage 8: sign and magnitude
  logic [PW-1:0]  mag8, den8;
  rlc_pkg::dtag_t tag8;

  always_ff @(posedge clk) begin
    if (en) begin
      mag8      <= num7[PW-1] ? $unsigned(-num7) : $unsigned(num7);
      den8      <= den7;
      tag8.neg  <= num7[PW-1];
      tag8.proj <= proj7;
      tag8.zero <= zero7;
    end
  end

  // stages 9..QB+9: divider
  logic [QB-1:0]  quo;
  logic           ovf;
  rlc_pkg::dtag_t dtag;

  rlc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .en, .mag(mag8), .den(den8), .tag(tag8),
    .quo, .ovf, .tag_out(dtag)
  );

  // last stage: round half away, saturate
  logic [QB:0]    rsum;
  logic [QB-1:0]  rmag;
  logic           sat;
  rlc_pkg::rsp_t  res, res_q;

  assign rsum = {1'b0, quo} + (QB+1)'(1);
  assign rmag = rsum[QB:1];
  assign sat  = ovf || (dtag.neg ? (rmag > QB'(33'h0_8000_0000))
                                 : (rmag > QB'(33'h0_7FFF_FFFF)));

  always_comb begin
    res.found           = !dtag.zero && !sat;
    res.used_projection = !dtag.zero && dtag.proj;
    if (dtag.zero) begin
      res.line_param = '0;
    end else if (sat) begin
      res.line_param = dtag.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res.line_param = dtag.neg ? -$signed(rmag[31:0]) : $signed(rmag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= res;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], req_valid};
    end
  end

  // output register plus spare
  logic          out_v, sp_v, out_take;
  rlc_pkg::rsp_t out_d, sp_d;

  assign en        = !sp_v;
  assign req_ready = en;
  assign out_take  = out_v && rsp_ready;
  assign rsp_valid = out_v;
  assign rsp       = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sp_v  <= 1'b0;
    end else if (sp_v) begin
      if (out_take) begin
        out_d <= sp_d;
        sp_v  <= 1'b0;
      end
    end else if (vld[NS-1]) begin
      if (!out_v || out_take) begin
        out_d <= res_q;
        out_v <= 1'b1;
      end else begin
        sp_d <= res_q;
        sp_v <= 1'b1;
      end
    end else if (out_take) begin
      out_v <= 1'b0;
    end
  end

  // checks
  logic [7:0] occ;
  assign occ = 8'($countones(vld)) + 8'(out_v) + 8'(sp_v);

  a_occ_in: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !out_take) |=> occ == $past(occ) + 8'd1)
    else $error("request lost or duplicated in pipeline");

  a_occ_out: assert property (@(posedge clk) disable iff (rst)
    (!(req_valid && req_ready) && out_take) |=> occ == $past(occ) - 8'd1)
    else $error("response lost or duplicated");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found && rsp.line_param != '0) |->
      (rsp.line_param == 32'sh7FFF_FFFF || rsp.line_param == 32'sh8000_0000))
    else $error("unfound result not clamped");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.used_projection && !rsp.found) |-> rsp.line_param != '0)
    else $error("projection flagged on zero-length direction");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for ray_line_closest_param: directed table, then random queries.
// Checks every response against a fixed-point predictor or a typed row's
// answer, across thresholds. Depends on rlc_pkg and ray_line_closest_param.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    rlc_pkg::req_t q;
    bit            typed;
    rlc_pkg::rsp_t r;
  } row_t;

  logic clk = 0, rst = 1;
  logic req_valid = 0, rsp_ready = 0;
  rlc_pkg::req_t req = '0;
  logic rsp_valid, req_ready, pready;
  rlc_pkg::rsp_t rsp;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [rlc_pkg::AW-1:0] paddr = '0;
  logic [rlc_pkg::DW-1:0] pwdata = '0, prdata;

  logic [31:0] thr_cfg = rlc_pkg::THR_RESET;
  rlc_pkg::rsp_t answer_q[$];
  row_t rows[$];
  int errors = 0, n_sent = 0, n_rcvd = 0, n_proj = 0, n_sat = 0;
  bit no_idle = 0;

  ray_line_closest_param dut (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic rlc_pkg::rsp_t closest_param(rlc_pkg::req_t r, logic [31:0] thr);
    logic signed [191:0] ro[3], u[3], lo[3], v[3], w[3];
    logic signed [191:0] uu, vv, uv, uw, vw, det, num, den, q;
    logic proj, sat;
    rlc_pkg::rsp_t o;
    ro[0] = r.ray_origin_x;  ro[1] = r.ray_origin_y;  ro[2] = r.ray_origin_z;
    u[0]  = r.ray_dir_x;     u[1]  = r.ray_dir_y;     u[2]  = r.ray_dir_z;
    lo[0] = r.axis_origin_x; lo[1] = r.axis_origin_y; lo[2] = r.axis_origin_z;
    v[0]  = r.axis_dir_x;    v[1]  = r.axis_dir_y;    v[2]  = r.axis_dir_z;
    for (int i = 0; i < 3; i++) w[i] = lo[i] - ro[i];
    o = '0;
    uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    if (uu == 0 || vv == 0) return o;
    uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    uw = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    vw = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    det = uu*vv - uv*uv;
    if (det < 0) det = -det;
    proj = 0;
    if (det > 192'(thr)) begin
      num = uw*vv - vw*uv;
      if (num < 0) proj = 1;
      else begin
        num = uw*uv - vw*uu;
        den = det;
      end
    end else proj = 1;
    if (proj) begin
      num = -vw;
      den = vv;
    end
    q = (((num < 0) ? -num : num) <<< (rlc_pkg::FRAC_BITS_DEF + 1)) / den;
    q = (q + 1) >>> 1;
    if (num < 0) begin
      sat = q > 192'sh8000_0000;
      o.line_param = sat ? 32'sh8000_0000 : -q[31:0];
    end else begin
      sat = q > 192'sh7FFF_FFFF;
      o.line_param = sat ? 32'sh7FFF_FFFF : q[31:0];
    end
    o.found = !sat;
    o.used_projection = proj;
    return o;
  endfunction

  function automatic rlc_pkg::req_t mk_req(int a0, a1, a2, a3, a4, a5, a6, a7, a8,
                                           a9, a10, a11);
    rlc_pkg::req_t r;
    r = '{a0, a1, a2, a3, a4, a5, a6, a7, a8, a9, a10, a11};
    return r;
  endfunction

  task automatic add_row(rlc_pkg::req_t q, bit typed, rlc_pkg::rsp_t r);
    row_t row;
    row.q = q;
    row.typed = typed;
    row.r = r;
    rows.insert(rows.size(), row);
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (no_idle || k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rnd_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic rlc_pkg::req_t rnd_query();
    rlc_pkg::req_t r;
    int k, sc;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      1, 5: r = mk_req(rnd_span(1 << 22), rnd_span(1 << 22), rnd_span(1 << 22),
                       rnd_span(1 << 18), rnd_span(1 << 18), rnd_span(1 << 18),
                       rnd_span(1 << 22), rnd_span(1 << 22), rnd_span(1 << 22),
                       rnd_span(1 << 18), rnd_span(1 << 18), rnd_span(1 << 18));
      2: r = mk_req(rnd_span(1 << 10), rnd_span(1 << 10), rnd_span(1 << 10),
                    rnd_span(3), rnd_span(3), rnd_span(3),
                    rnd_span(1 << 10), rnd_span(1 << 10), rnd_span(1 << 10),
                    rnd_span(3), rnd_span(3), rnd_span(3));
      3: begin
        k = rnd_span(4);
        sc = $urandom_range(0, 3);
        r = mk_req(rnd_span(1 << 20), rnd_span(1 << 20), rnd_span(1 << 20),
                   rnd_span(1 << 14), rnd_span(1 << 14), rnd_span(1 << 14),
                   rnd_span(1 << 20), rnd_span(1 << 20), rnd_span(1 << 20), 0, 0, 0);
        r.axis_dir_x = r.ray_dir_x * k + rnd_span(sc);
        r.axis_dir_y = r.ray_dir_y * k + rnd_span(sc);
        r.axis_dir_z = r.ray_dir_z * k + rnd_span(sc);
      end
      4: if ($urandom_range(0, 1)) {r.ray_dir_x, r.ray_dir_y, r.ray_dir_z} = '0;
         else {r.axis_dir_x, r.axis_dir_y, r.axis_dir_z} = '0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic apb_write(logic [rlc_pkg::AW-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[rlc_pkg::AW-1:2] == rlc_pkg::REG_THR) thr_cfg = data;
    @(negedge clk);
    pwrite <= 0;
    penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[rlc_pkg::AW-1:2] == rlc_pkg::REG_THR && prdata !== data) begin
      $error("prdata exp %h got %h", data, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 0; penable <= 0;
  endtask

  task automatic send_query(rlc_pkg::req_t r, bit typed, rlc_pkg::rsp_t exp);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(negedge clk);
    end
    req_valid <= 1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    answer_q.insert(answer_q.size(), typed ? exp : closest_param(r, thr_cfg));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 0;
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (no_idle) rsp_ready <= 1;
    else rsp_ready <= (gap_len() == 0);
  end

  always @(posedge clk) begin
    rlc_pkg::rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      n_rcvd++;
      if (answer_q.size() == 0) begin
        $error("response with no request pending");
        errors++;
      end else begin
        e = answer_q.pop_front();
        n_proj += e.used_projection;
        n_sat += (!e.found && e.line_param != 0);
        if (rsp.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, rsp.found);
          errors++;
        end
        if (rsp.line_param !== e.line_param) begin
          $error("line_param exp %h got %h", e.line_param, rsp.line_param);
          errors++;
        end
        if (rsp.used_projection !== e.used_projection) begin
          $error("used_projection exp %0d got %0d", e.used_projection,
                 rsp.used_projection);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] thr_list[5];
    int lim;
    add_row(mk_req(32'h7fffffff, -5, 3, 0, 0, 0, 4, 5, 6, 65536, 0, 0),
            1, '{0, 0, 0});
    add_row(mk_req(1, 2, 32'h80000000, 65536, 7, 0, 4, 5, 6, 0, 0, 0),
            1, '{0, 0, 0});
    add_row(mk_req(0, 0, 0, 65536, 0, 0, 5 << 16, 3 << 16, 0, 0, 65536, 0),
            1, '{1, -196608, 0});
    add_row(mk_req(0, 0, 0, 65536, 0, 0, -(5 << 16), 3 << 16, 0, 0, 65536, 0),
            1, '{1, -196608, 1});
    add_row({12{32'h7fffffff}}, 1, '{1, 0, 1});
    add_row({12{32'h80000000}}, 1, '{1, 0, 1});
    add_row(mk_req(0, 32'h7fffffff, 0, 1, 0, 0, 0, 32'h80000000, 0, 0, 1, 0),
            1, '{0, 32'h7fffffff, 1});
    add_row(mk_req(0, 32'h80000000, 0, 1, 0, 0, 0, 32'h7fffffff, 0, 0, 1, 0),
            1, '{0, 32'h80000000, 1});
    add_row(mk_req(0, 0, 0, 65536, 0, 0, 7, 9, 2, 131072, 0, 0), 0, '0);
    add_row(mk_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff),
            0, '0);
    add_row(mk_req(0, 0, 0, 1, 0, 0, 3, 5, 0, 1, 1, 0), 0, '0);
    add_row(mk_req(0, 0, 0, 2, 1, 0, 30, 50, 7, 1, 1, 0), 0, '0);
    add_row(mk_req(-3, 8, 1, 65536, -65536, 4, 1 << 20, -(1 << 19), 9, 3, 65536,
                   -65536), 0, '0);
    thr_list = '{32'd1, 32'd0, 32'hFFFFFFFF, 32'd3, 32'd1};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].r);
    drain();

    for (int p = 0; p < 5; p++) begin
      apb_write(3'd4, $urandom);
      apb_write(3'd0, (p == 3) ? $urandom_range(2, 1 << 12) : thr_list[p]);
      for (int n = 0; n < 300; n++) begin
        if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
        send_query(rnd_query(), 0, '0);
      end
      no_idle = 0;
      drain();
    end

    lim = 0;
    while (answer_q.size() != 0 && lim < 10000) begin
      @(posedge clk);
      lim++;
    end
    repeat (60) @(posedge clk);
    $display("%0d queries sent, %0d responses checked (%0d by projection, %0d saturated)",
             n_sent, n_rcvd, n_proj, n_sat);
    $display("thresholds covered: 0, 1, small, max; %0d errors", errors);
    if (errors == 0 && answer_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
src/rlc_pkg.sv
src/rlc_mul.sv
src/rlc_div.sv
src/ray_line_closest_param.sv
test/tb_top.sv
